FILE: rtl/tpf_pkg.sv
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared types and constants of the top three peak finder.
// ----------------------------------------------------------------------------
package tpf_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int MAX_POINTS  = 256;
   localparam int POS_BITS    = $clog2(MAX_POINTS);
   localparam int NUM_RANKS   = 3;
   localparam int RANK_BITS   = 2;

   localparam logic [RANK_BITS-1:0] RANK_FIRST  = 2'd0;
   localparam logic [RANK_BITS-1:0] RANK_SECOND = 2'd1;
   localparam logic [RANK_BITS-1:0] RANK_THIRD  = 2'd2;

   localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(MAX_POINTS - 1);

   typedef struct packed {
      logic                   filled;
      logic [POS_BITS-1:0]    position;
      logic [SAMPLE_BITS-1:0] value;
   } entry_type;

   typedef entry_type [NUM_RANKS-1:0] ranks_type;

endpackage

FILE: rtl/tpf_update.sv
// ----------------------------------------------------------------------------
// tpf_update
// Compare and shift of one sample into the three kept maxima.
// ----------------------------------------------------------------------------
module tpf_update (
   input  tpf_pkg::ranks_type                 best,
   input  logic [tpf_pkg::SAMPLE_BITS-1:0]    sample,
   input  logic [tpf_pkg::POS_BITS-1:0]       position,
   output tpf_pkg::ranks_type                 best_next
);

   tpf_pkg::entry_type fresh;
   logic               hit_first;
   logic               hit_second;
   logic               hit_third;

   always_comb begin
      fresh.filled   = 1'b1;
      fresh.position = position;
      fresh.value    = sample;

      hit_first  = !best[0].filled || (sample > best[0].value);
      hit_second = (!best[1].filled || (sample > best[1].value)) &&
                   (sample < best[0].value);
      hit_third  = best[1].filled && (!best[2].filled || (sample > best[2].value)) &&
                   (sample < best[1].value);

      best_next = best;
      if (hit_first) begin
         best_next[2] = best[1];
         best_next[1] = best[0];
         best_next[0] = fresh;
      end else if (hit_second) begin
         best_next[2] = best[1];
         best_next[1] = fresh;
      end else if (hit_third) begin
         best_next[2] = fresh;
      end
   end

endmodule

FILE: rtl/tpf_drain.sv
// ----------------------------------------------------------------------------
// tpf_drain
// Holds the three ranks of a finished sweep and hands them out one by one.
// ----------------------------------------------------------------------------
module tpf_drain (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  tpf_pkg::ranks_type                ranks,
   output logic                              free,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tpf_pkg::RANK_BITS-1:0]     rsp_rank,
   output logic [tpf_pkg::POS_BITS-1:0]      rsp_position,
   output logic [tpf_pkg::SAMPLE_BITS-1:0]   rsp_peak_value,
   output logic                              rsp_found,
   output logic                              rsp_final_result
);

   tpf_pkg::ranks_type                  hold_ff;
   tpf_pkg::ranks_type                  hold_in;
   logic                                busy_ff;
   logic                                busy_in;
   logic [tpf_pkg::RANK_BITS-1:0]       rank_ff;
   logic [tpf_pkg::RANK_BITS-1:0]       rank_in;
   tpf_pkg::entry_type                  cur;
   logic                                done;

   assign done = busy_ff && rsp_ready && (rank_ff == tpf_pkg::RANK_THIRD);
   assign free = !busy_ff || done;

   always_comb begin
      hold_in = hold_ff;
      busy_in = busy_ff;
      rank_in = rank_ff;
      if (load) begin
         for (int k = 0; k < tpf_pkg::NUM_RANKS; k++) begin
            hold_in[k].filled   = ranks[k].filled;
            hold_in[k].position = ranks[k].filled ? ranks[k].position : '0;
            hold_in[k].value    = ranks[k].filled ? ranks[k].value : '0;
         end
         busy_in = 1'b1;
         rank_in = tpf_pkg::RANK_FIRST;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         rank_in = rank_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rank_ff <= tpf_pkg::RANK_FIRST;
      end else begin
         busy_ff <= busy_in;
         rank_ff <= rank_in;
      end
      hold_ff <= hold_in;
   end

   always_comb begin
      case (rank_ff)
         tpf_pkg::RANK_FIRST:  cur = hold_ff[0];
         tpf_pkg::RANK_SECOND: cur = hold_ff[1];
         tpf_pkg::RANK_THIRD:  cur = hold_ff[2];
         default:              cur = hold_ff[2];
      endcase
   end

   assign rsp_valid        = busy_ff;
   assign rsp_rank         = rank_ff;
   assign rsp_position     = cur.position;
   assign rsp_peak_value   = cur.value;
   assign rsp_found        = cur.filled;
   assign rsp_final_result = (rank_ff == tpf_pkg::RANK_THIRD);

endmodule

FILE: rtl/top_three_peak_finder.sv
// ----------------------------------------------------------------------------
// top_three_peak_finder
// Tracks the three largest distinct codes of a sweep and their positions.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one sample per item, req_last high on the final sample.
//   rsp channel: after a last sample, three items, ranks 0, 1 and 2, with
//   position, peak value and found; rsp_final_result marks rank 2.
//   Throughput: one sample per cycle while no last sample is held waiting;
//   the input register and the kept ranks update in a single compare-and-shift step per item.
//   Rank 0 is presented once the last sample has left the input register
//   and loaded the drain; ranks 1 and 2 follow as rsp_ready takes each.
//   Samples of the next sweep keep flowing while the ranks drain; a last
//   sample waits in the input register only while the previous three
//   results are still not taken, so a stalled receiver backs up the input.
//   Reset (synchronous, active high) empties all ranks, zeroes the position
//   counter and drops any pending results.
//   Positions count from 0 and stop at the top of the counter.
// ----------------------------------------------------------------------------
module top_three_peak_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tpf_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tpf_pkg::RANK_BITS-1:0]     rsp_rank,
   output logic [tpf_pkg::POS_BITS-1:0]      rsp_position,
   output logic [tpf_pkg::SAMPLE_BITS-1:0]   rsp_peak_value,
   output logic                              rsp_found,
   output logic                              rsp_final_result
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [tpf_pkg::SAMPLE_BITS-1:0]   in_sample_ff;
   logic                              in_last_ff;
   tpf_pkg::ranks_type                best_ff;
   tpf_pkg::ranks_type                best_in;
   tpf_pkg::ranks_type                best_next;
   logic [tpf_pkg::POS_BITS-1:0]      index_ff;
   logic [tpf_pkg::POS_BITS-1:0]      index_in;
   logic                              drain_free;
   logic                              fire;
   logic                              take;

   assign fire      = in_valid_ff && (!in_last_ff || drain_free);
   assign req_ready = !in_valid_ff || fire;
   assign take      = req_valid && req_ready;

   tpf_update u_update (
      .best      (best_ff),
      .sample    (in_sample_ff),
      .position  (index_ff),
      .best_next (best_next)
   );

   always_comb begin
      in_valid_in = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      best_in     = best_ff;
      index_in    = index_ff;
      if (fire) begin
         if (in_last_ff) begin
            best_in  = '0;
            index_in = '0;
         end else begin
            best_in = best_next;
            if (index_ff != tpf_pkg::LAST_POS) begin
               index_in = index_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         best_ff     <= '0;
         index_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         best_ff     <= best_in;
         index_ff    <= index_in;
      end
      if (take) begin
         in_sample_ff <= req_sample;
         in_last_ff   <= req_last;
      end
   end

   tpf_drain u_drain (
      .clock            (clock),
      .reset            (reset),
      .load             (fire && in_last_ff),
      .ranks            (best_next),
      .free             (drain_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank         (rsp_rank),
      .rsp_position     (rsp_position),
      .rsp_peak_value   (rsp_peak_value),
      .rsp_found        (rsp_found),
      .rsp_final_result (rsp_final_result)
   );

endmodule
